/* rtl/tfn_pkg.sv */
// Shared types and constants of the triangle face normal assembler.
package tfn_pkg;

  localparam int COORD_W   = 20;
  localparam int NORMAL_W  = 16;
  localparam int INDEX_W   = 16;
  localparam int DIFF_W    = 21;
  localparam int CROSS_W   = 42;
  localparam int MAG_W     = 41;
  localparam int SQ_W      = 82;
  localparam int SUM_W     = 84;
  localparam int ACC_W     = 116;
  localparam int QS_W      = 100;
  localparam int QUOT_W    = 15;
  localparam int IDXCMP_W  = 17;
  localparam int DATA_W    = 112;

  localparam logic       OP_VERTEX = 1'b0;
  localparam logic       OP_FACE   = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DEGEN  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NORMAL_W-1:0] normal_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vertex_t;

  typedef struct packed {
    logic done;
    logic degen;
  } norm_stat_t;

  typedef enum logic [1:0] {T_IDLE, T_READ, T_CALC, T_EMIT} top_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_DIFF, N_CROSS, N_CHECK, N_SQ, N_SUM, N_DIV, N_FIN
  } norm_state_t;

endpackage

/* rtl/tfn_vstore.sv */
// Vertex store: one write port, one read port with registered read data.
module tfn_vstore #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tfn_pkg::vertex_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output tfn_pkg::vertex_t rd_data
);
  import tfn_pkg::*;

  vertex_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/tfn_norm.sv */
// Face normal unit: cross product, squared length and bit-serial normalization.
module tfn_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tfn_pkg::vertex_t   v0,
  input  tfn_pkg::vertex_t   v1,
  input  tfn_pkg::vertex_t   v2,
  output tfn_pkg::norm_stat_t stat,
  output tfn_pkg::normal_t   nx,
  output tfn_pkg::normal_t   ny,
  output tfn_pkg::normal_t   nz
);
  import tfn_pkg::*;

  norm_state_t state, state_next;

  logic signed [DIFF_W-1:0]  ax, ay, az, bx, by, bz;
  logic signed [CROSS_W-1:0] p1, p2;
  logic signed [CROSS_W-1:0] c [3];
  logic [SQ_W-1:0]           sq [3];
  logic [SQ_W-1:0]           prod;
  logic [1:0]                prod_k;
  logic                      prod_v;
  logic [SUM_W-1:0]          s;
  logic [ACC_W-1:0]          pacc;
  logic [QS_W-1:0]           qacc;
  logic [QUOT_W-1:0]         q;
  logic [3:0]                step;
  logic [1:0]                comp;
  logic [1:0]                part;
  logic [3:0]                bitn;
  logic                      degen;

  logic signed [CROSS_W-1:0] c_sel;
  logic [CROSS_W-1:0]        c_abs;
  logic [MAG_W-1:0]          mag;
  logic [ACC_W-1:0]          trial, rhs;
  logic                      zero;

  function automatic normal_t final_res(logic signed [CROSS_W-1:0] cv,
                                        logic [QUOT_W-1:0] qv, logic take);
    logic [QUOT_W-1:0] qf;
    qf = qv | QUOT_W'(take);
    return cv[CROSS_W-1] ? NORMAL_W'(-$signed({1'b0, qf})) : NORMAL_W'(qf);
  endfunction

  assign zero = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);

  always_comb begin
    case (comp)
      2'd0:    c_sel = c[0];
      2'd1:    c_sel = c[1];
      default: c_sel = c[2];
    endcase
    c_abs = c_sel[CROSS_W-1] ? CROSS_W'(-c_sel) : CROSS_W'(c_sel);
    mag   = c_abs[MAG_W-1:0];
  end

  // Trial of the next quotient bit: (q + 2^b)^2 s = q^2 s + 2^(b+1) q s + 2^(2b) s.
  always_comb begin
    logic [SQ_W-1:0] sq_sel;
    case (comp)
      2'd0:    sq_sel = sq[0];
      2'd1:    sq_sel = sq[1];
      default: sq_sel = sq[2];
    endcase
    rhs   = ACC_W'(sq_sel) << 28;
    trial = pacc + (ACC_W'(qacc) << (5'(bitn) + 5'd1)) + (ACC_W'(s) << {bitn, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.done  = 1'b0;
    stat.degen = degen;
    case (state)
      N_IDLE:  if (start) state_next = N_DIFF;
      N_DIFF:  state_next = N_CROSS;
      N_CROSS: if (step == 4'd3) state_next = N_CHECK;
      N_CHECK: state_next = zero ? N_FIN : N_SQ;
      N_SQ:    if (step == 4'd9) state_next = N_SUM;
      N_SUM:   state_next = N_DIV;
      N_DIV:   if (comp == 2'd2 && bitn == 4'd0) state_next = N_FIN;
      N_FIN: begin
        stat.done  = 1'b1;
        state_next = N_IDLE;
      end
      default: state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        step <= '0;
      end
      N_DIFF: begin
        ax <= DIFF_W'(v0.x) - DIFF_W'(v1.x);
        ay <= DIFF_W'(v0.y) - DIFF_W'(v1.y);
        az <= DIFF_W'(v0.z) - DIFF_W'(v1.z);
        bx <= DIFF_W'(v0.x) - DIFF_W'(v2.x);
        by <= DIFF_W'(v0.y) - DIFF_W'(v2.y);
        bz <= DIFF_W'(v0.z) - DIFF_W'(v2.z);
        step <= '0;
      end
      N_CROSS: begin
        case (step)
          4'd0: begin p1 <= ay * bz; p2 <= by * az; end
          4'd1: begin p1 <= bx * az; p2 <= ax * bz; end
          default: begin p1 <= ax * by; p2 <= bx * ay; end
        endcase
        if (step != 4'd0) begin
          c[2'(step - 4'd1)] <= p1 - p2;
        end
        step <= step + 4'd1;
      end
      N_CHECK: begin
        step   <= '0;
        comp   <= '0;
        part   <= '0;
        prod_v <= 1'b0;
        sq[0]  <= '0;
        sq[1]  <= '0;
        sq[2]  <= '0;
        degen  <= zero;
        if (zero) begin
          nx <= '0;
          ny <= '0;
          nz <= '0;
        end
      end
      N_SQ: begin
        // Squares from partial products of the 21-bit low and 20-bit high halves, one per cycle.
        if (prod_v) begin
          sq[prod_k] <= sq[prod_k] + prod;
        end
        if (step != 4'd9) begin
          case (part)
            2'd0:    prod <= SQ_W'(mag[20:0] * mag[20:0]);
            2'd1:    prod <= SQ_W'(mag[40:21] * mag[20:0]) << 22;
            default: prod <= SQ_W'(mag[40:21] * mag[40:21]) << 42;
          endcase
          prod_k <= comp;
          prod_v <= 1'b1;
          if (part == 2'd2) begin
            part <= '0;
            comp <= comp + 2'd1;
          end else begin
            part <= part + 2'd1;
          end
        end
        step <= step + 4'd1;
      end
      N_SUM: begin
        s    <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
        comp <= '0;
        bitn <= 4'd14;
        pacc <= '0;
        qacc <= '0;
        q    <= '0;
      end
      N_DIV: begin
        if (bitn == 4'd0) begin
          pacc <= '0;
          qacc <= '0;
          q    <= '0;
          bitn <= 4'd14;
          comp <= comp + 2'd1;
        end else begin
          if (trial <= rhs) begin
            pacc    <= trial;
            qacc    <= qacc + (QS_W'(s) << bitn);
            q[bitn] <= 1'b1;
          end
          bitn <= bitn - 4'd1;
        end
      end
      default: ;
    endcase
    // Bit zero decides the last quotient bit, so the result is written from the trial.
    if (state == N_DIV && bitn == 4'd0) begin
      case (comp)
        2'd0:    nx <= final_res(c_sel, q, trial <= rhs);
        2'd1:    ny <= final_res(c_sel, q, trial <= rhs);
        default: nz <= final_res(c_sel, q, trial <= rhs);
      endcase
    end
  end

endmodule

/* rtl/triangle_face_normal_assembler_top.sv */
// Top level of the triangle face normal assembler: item control, store and output.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata (positions, indices), s_tuser (operation)
//  m_*     | out | m_tvalid/m_tready  | m_tdata (corner, normal, number), m_tuser, m_tlast
//
// A vertex word is taken while idle and written to the store unless it is full. A face
// with valid indices has its corners read from the store, then passes through the normal
// unit, dominated by its 45-step bit-serial normalization (15 quotient bits per component),
// then leaves as three output words. A face with a bad index goes straight to its three output words.
// Reset clears the state machines and the vertex count; the store is not cleared.
// A stall on the output holds the current word; no input is taken until a face's
// last word is gone.
module triangle_face_normal_assembler_top #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_x, pos_y, pos_z, first_index, second_index, third_index, zero fill
  input  logic [tfn_pkg::DATA_W-1:0]  s_tdata,
  // operation
  input  logic [0:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // corner_x, corner_y, corner_z, normal_x, normal_y, normal_z, corner_number, zero fill
  output logic [tfn_pkg::DATA_W-1:0]  m_tdata,
  // status
  output logic [1:0]                  m_tuser,
  output logic                        m_tlast
);
  import tfn_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  top_state_t state, state_next;

  logic [CW-1:0]      count;
  logic [INDEX_W-1:0] idx [3];
  vertex_t            vtx [3];
  normal_t            nrm_x, nrm_y, nrm_z;
  logic [1:0]         status;
  logic [1:0]         corner;
  logic [1:0]         rd;

  logic               accept, out_take, bad, full, start;
  logic [AW-1:0]      rd_addr;
  vertex_t            rd_data, in_vtx, cur;
  norm_stat_t         nstat;
  normal_t            ux, uy, uz;
  logic [INDEX_W-1:0] in_idx [3];

  assign in_vtx.x  = s_tdata[19:0];
  assign in_vtx.y  = s_tdata[39:20];
  assign in_vtx.z  = s_tdata[59:40];
  assign in_idx[0] = s_tdata[75:60];
  assign in_idx[1] = s_tdata[91:76];
  assign in_idx[2] = s_tdata[107:92];

  assign accept   = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;
  assign full     = (count >= CW'(MAX_VERTICES));

  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (in_idx[k] == '0 || IDXCMP_W'(in_idx[k]) > IDXCMP_W'(count)) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    case (rd)
      2'd0:    rd_addr = AW'(idx[0] - INDEX_W'(1));
      2'd1:    rd_addr = AW'(idx[1] - INDEX_W'(1));
      default: rd_addr = AW'(idx[2] - INDEX_W'(1));
    endcase
  end

  tfn_vstore #(.DEPTH(MAX_VERTICES), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (accept && s_tuser[0] == OP_VERTEX && !full),
    .wr_addr (AW'(count)),
    .wr_data (in_vtx),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tfn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .v0    (vtx[0]),
    .v1    (vtx[1]),
    .v2    (vtx[2]),
    .stat  (nstat),
    .nx    (ux),
    .ny    (uy),
    .nz    (uz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    start      = 1'b0;
    case (state)
      T_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tuser[0] == OP_FACE) begin
          state_next = bad ? T_EMIT : T_READ;
        end
      end
      T_READ: begin
        if (rd == 2'd3) begin
          start      = 1'b1;
          state_next = T_CALC;
        end
      end
      T_CALC: if (nstat.done) state_next = T_EMIT;
      T_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready && corner == 2'd2) state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && s_tuser[0] == OP_VERTEX && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        rd     <= '0;
        corner <= '0;
        if (accept && s_tuser[0] == OP_FACE) begin
          idx <= in_idx;
          if (bad) begin
            vtx[0] <= '0;
            vtx[1] <= '0;
            vtx[2] <= '0;
            nrm_x  <= '0;
            nrm_y  <= '0;
            nrm_z  <= '0;
            status <= ST_BAD;
          end
        end
      end
      T_READ: begin
        if (rd != 2'd0) begin
          vtx[2'(rd - 2'd1)] <= rd_data;
        end
        if (rd != 2'd3) begin
          rd <= rd + 2'd1;
        end
      end
      T_CALC: begin
        if (nstat.done) begin
          nrm_x  <= ux;
          nrm_y  <= uy;
          nrm_z  <= uz;
          status <= nstat.degen ? ST_DEGEN : ST_OK;
        end
      end
      T_EMIT: if (out_take) corner <= corner + 2'd1;
      default: ;
    endcase
  end

  always_comb begin
    case (corner)
      2'd0:    cur = vtx[0];
      2'd1:    cur = vtx[1];
      default: cur = vtx[2];
    endcase
  end

  assign m_tdata = {2'b00, corner, nrm_z, nrm_y, nrm_x, cur.z, cur.y, cur.x};
  assign m_tuser = status;
  assign m_tlast = (corner == 2'd2);

endmodule

/* rtl/tfn_checker.sv */
// Port checker of the face normal assembler and its bind.
module tfn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [tfn_pkg::DATA_W-1:0] m_tdata,
  input logic [1:0]                 m_tuser,
  input logic                       m_tlast
);
  import tfn_pkg::*;

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[109:108] == 2'd2)))
    else $error("tlast does not match the corner number");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_BAD) |-> m_tdata[107:0] == '0)
    else $error("bad index word carries data");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_DEGEN) |-> m_tdata[107:60] == '0)
    else $error("degenerate face has a nonzero normal");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while a face is being delivered");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

endmodule

bind triangle_face_normal_assembler_top tfn_checker u_tfn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* bench/tb_triangle_face_normal_assembler_top.sv */
// Self-checking testbench for the triangle face normal assembler top level.
`timescale 1ns / 1ps

module tb_triangle_face_normal_assembler_top;
  import tfn_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int STALL_LIMIT = 3000;

  // One stimulus word; pinned rows carry a status and normal read straight off the math.
  typedef struct packed {
    logic              op;
    coord_t            px;
    coord_t            py;
    coord_t            pz;
    logic [INDEX_W-1:0] i1;
    logic [INDEX_W-1:0] i2;
    logic [INDEX_W-1:0] i3;
    logic              pinned;
    logic [1:0]        pin_st;
    normal_t           pin_nx;
    normal_t           pin_ny;
    normal_t           pin_nz;
  } mesh_word_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    coord_t     z;
    normal_t    nx;
    normal_t    ny;
    normal_t    nz;
    logic [1:0] num;
    logic       last;
    logic [1:0] st;
  } corner_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic [0:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;

  vertex_t      mesh_pts [STORE_DEPTH];
  int unsigned  pts_n = 0;
  corner_word_t corners_due [$];
  int           errors = 0;
  bit           quiet = 1'b0;
  int           hold_off = 0;
  int           idle_cycles = 0;
  mesh_word_t   plan [21];

  triangle_face_normal_assembler_top #(.MAX_VERTICES(STORE_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Largest q with q^2 * s <= c^2 * 2^28, signed like c.
  function automatic normal_t unit_part(input logic signed [127:0] c, input logic [127:0] s);
    logic [127:0] a;
    logic [127:0] rhs;
    logic [127:0] t;
    logic [127:0] q;
    a = (c < 0) ? -c : c;
    rhs = (a * a) << 28;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      t = q | (128'd1 << b);
      if (s * t * t <= rhs) q = t;
    end
    return (c < 0) ? normal_t'(-q) : normal_t'(q);
  endfunction

  task automatic track_word(input mesh_word_t w);
    logic [INDEX_W-1:0] ix [3];
    vertex_t v [3];
    logic [1:0] st;
    logic signed [127:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [127:0] s;
    normal_t nx, ny, nz;
    corner_word_t e;
    if (w.op == OP_VERTEX) begin
      if (pts_n < STORE_DEPTH) begin
        mesh_pts[pts_n] = '{z: w.pz, y: w.py, x: w.px};
        pts_n++;
      end
      return;
    end
    ix[0] = w.i1; ix[1] = w.i2; ix[2] = w.i3;
    st = ST_OK;
    nx = '0; ny = '0; nz = '0;
    for (int k = 0; k < 3; k++) begin
      v[k] = '0;
      if (ix[k] == 0 || ix[k] > pts_n) st = ST_BAD;
    end
    if (st == ST_OK) begin
      for (int k = 0; k < 3; k++) v[k] = mesh_pts[ix[k] - 1];
      ax = v[0].x - v[1].x; ay = v[0].y - v[1].y; az = v[0].z - v[1].z;
      bx = v[0].x - v[2].x; by = v[0].y - v[2].y; bz = v[0].z - v[2].z;
      cx = ay * bz - by * az;
      cy = bx * az - ax * bz;
      cz = ax * by - bx * ay;
      if (cx == 0 && cy == 0 && cz == 0) begin
        st = ST_DEGEN;
      end else begin
        s = cx * cx + cy * cy + cz * cz;
        nx = unit_part(cx, s);
        ny = unit_part(cy, s);
        nz = unit_part(cz, s);
      end
    end
    if (w.pinned) begin
      st = w.pin_st; nx = w.pin_nx; ny = w.pin_ny; nz = w.pin_nz;
    end
    for (int k = 0; k < 3; k++) begin
      e = '{x: v[k].x, y: v[k].y, z: v[k].z, nx: nx, ny: ny, nz: nz,
            num: 2'(k), last: (k == 2), st: st};
      corners_due.push_back(e);
    end
  endtask

  task automatic offer(input mesh_word_t w);
    if (!quiet && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tdata  <= {4'b0, w.i3, w.i2, w.i1, w.pz, w.py, w.px};
    s_tuser  <= w.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    track_word(w);
  endtask

  function automatic mesh_word_t random_word();
    mesh_word_t w;
    int r;
    int unsigned bad;
    w = '0;
    w.px = coord_t'($urandom); w.py = coord_t'($urandom); w.pz = coord_t'($urandom);
    w.i1 = INDEX_W'($urandom); w.i2 = INDEX_W'($urandom); w.i3 = INDEX_W'($urandom);
    r = $urandom_range(99);
    if (pts_n < 3 || r < 45) begin
      w.op = OP_VERTEX;
      // Small coordinates keep the cross products in a moderate range now and then.
      if ($urandom_range(1) == 0) begin
        w.px = coord_t'($signed($urandom_range(2048)) - 1024);
        w.py = coord_t'($signed($urandom_range(2048)) - 1024);
        w.pz = coord_t'($signed($urandom_range(2048)) - 1024);
      end
      return w;
    end
    w.op = OP_FACE;
    w.i1 = INDEX_W'($urandom_range(pts_n, 1));
    w.i2 = INDEX_W'($urandom_range(pts_n, 1));
    w.i3 = INDEX_W'($urandom_range(pts_n, 1));
    if (r >= 80 && r < 88) begin
      w.i3 = w.i1;
    end else if (r >= 88) begin
      bad = $urandom_range(2);
      case (bad)
        0: w.i2 = '0;
        1: w.i3 = INDEX_W'(pts_n + $urandom_range(1, 100));
        default: w.i1 = INDEX_W'($urandom_range(65535, pts_n + 1));
      endcase
    end
    return w;
  endfunction

  // Output side: random backpressure, long hold-offs on request, and the checks.
  always @(posedge clk) begin
    corner_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (corners_due.size() == 0) begin
        report("unexpected output word", 1, 0);
      end else begin
        e = corners_due.pop_front();
        if (coord_t'(m_tdata[19:0]) != e.x) report("corner_x", coord_t'(m_tdata[19:0]), e.x);
        if (coord_t'(m_tdata[39:20]) != e.y) report("corner_y", coord_t'(m_tdata[39:20]), e.y);
        if (coord_t'(m_tdata[59:40]) != e.z) report("corner_z", coord_t'(m_tdata[59:40]), e.z);
        if (normal_t'(m_tdata[75:60]) != e.nx)
          report("normal_x", normal_t'(m_tdata[75:60]), e.nx);
        if (normal_t'(m_tdata[91:76]) != e.ny)
          report("normal_y", normal_t'(m_tdata[91:76]), e.ny);
        if (normal_t'(m_tdata[107:92]) != e.nz)
          report("normal_z", normal_t'(m_tdata[107:92]), e.nz);
        if (m_tdata[109:108] != e.num) report("corner_number", m_tdata[109:108], e.num);
        if (m_tlast != e.last) report("last_corner", m_tlast, e.last);
        if (m_tuser != e.st) report("status", m_tuser, e.st);
      end
    end
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mesh_word_t w;
    plan[0]  = '{OP_FACE,   0, 0, 0, 1, 2, 3, 1, ST_BAD, 0, 0, 0};
    plan[1]  = '{OP_VERTEX, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[2]  = '{OP_VERTEX, 256, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[3]  = '{OP_VERTEX, 0, 256, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[4]  = '{OP_FACE,   0, 0, 0, 1, 2, 3, 1, ST_OK, 0, 0, 16384};
    plan[5]  = '{OP_FACE,   0, 0, 0, 1, 3, 2, 1, ST_OK, 0, 0, -16384};
    plan[6]  = '{OP_FACE,   0, 0, 0, 0, 1, 2, 1, ST_BAD, 0, 0, 0};
    plan[7]  = '{OP_FACE,   0, 0, 0, 1, 2, 4, 1, ST_BAD, 0, 0, 0};
    plan[8]  = '{OP_FACE,   0, 0, 0, 65535, 1, 2, 1, ST_BAD, 0, 0, 0};
    plan[9]  = '{OP_VERTEX, 524287, 524287, 524287, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[10] = '{OP_VERTEX, -524288, -524288, -524288, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[11] = '{OP_VERTEX, 524287, -524288, 524287, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[12] = '{OP_FACE,   0, 0, 0, 4, 5, 6, 0, ST_OK, 0, 0, 0};
    plan[13] = '{OP_FACE,   0, 0, 0, 1, 1, 2, 1, ST_DEGEN, 0, 0, 0};
    plan[14] = '{OP_VERTEX, 512, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[15] = '{OP_FACE,   0, 0, 0, 1, 2, 7, 1, ST_DEGEN, 0, 0, 0};
    plan[16] = '{OP_FACE,   0, 0, 0, 6, 5, 4, 0, ST_OK, 0, 0, 0};
    plan[17] = '{OP_FACE,   0, 0, 0, 4, 6, 1, 0, ST_OK, 0, 0, 0};
    plan[18] = '{OP_VERTEX, -1, -1, -1, 0, 0, 0, 0, ST_OK, 0, 0, 0};
    plan[19] = '{OP_FACE,   0, 0, 0, 8, 4, 5, 0, ST_OK, 0, 0, 0};
    plan[20] = '{OP_FACE,   0, 0, 0, 2, 3, 8, 0, ST_OK, 0, 0, 0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i]);

    // Let the output drain completely before the random part starts.
    s_tvalid <= 1'b0;
    while (corners_due.size() != 0) @(posedge clk);

    // A long receiver stall while faces keep coming fills the block and stalls its input.
    hold_off <= 300;
    for (int n = 0; n < 88; n++) begin
      quiet = (n >= 40 && n < 65);
      w = random_word();
      if (n < 6 && pts_n >= 3) begin
        w.op = OP_FACE;
        w.i1 = 1; w.i2 = 2; w.i3 = 3;
      end
      offer(w);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (corners_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tfn_pkg.sv
rtl/tfn_vstore.sv
rtl/tfn_norm.sv
rtl/triangle_face_normal_assembler_top.sv
rtl/tfn_checker.sv
bench/tb_triangle_face_normal_assembler_top.sv
